@@ rtl/core/sitoa_pkg.sv @@
// shared types and constants for the signed integer to decimal ascii core
// no dependencies
package sitoa_pkg;

    // binary bits folded into the bcd register per conversion cycle
    localparam int BITS_PER_STEP = 4;

    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;

    // double dabble correction: a digit of five or more gets three added before the shift
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ       = 4'd3;

    typedef struct packed {
        logic start;
        logic conv_step;
        logic find;
        logic load_char;
    } sitoa_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_char;
    } sitoa_status_t;

endpackage

@@ rtl/core/sitoa_if.sv @@
// valid/ready channel interfaces: integer input and character output
// no dependencies
interface sitoa_value_if #(
    parameter int W = 32
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_char_if ();
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ rtl/core/sitoa_datapath.sv @@
// datapath: magnitude, shift-add-3 bcd conversion, leading digit search, output register
// depends on sitoa_pkg
module sitoa_datapath
    import sitoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] value,
    input  sitoa_cmd_t             cmd,
    output sitoa_status_t          status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             char_code,
    output logic                   last
);

    localparam int PAD_W = ((VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
    localparam int PTR_W = $clog2(MAX_DIGITS);

    logic [VALUE_WIDTH-1:0] magnitude;

    logic [PAD_W-1:0] shift_reg, shift_next;
    logic [3:0]       bcd_reg [MAX_DIGITS];
    logic [3:0]       bcd_next [MAX_DIGITS];
    logic             overflow_reg, overflow_next;
    logic             sign_reg, sign_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;

    logic [PAD_W-1:0] conv_bits;
    logic [3:0]       conv_digits [MAX_DIGITS];
    logic             conv_ovf;
    logic [PTR_W-1:0] top_idx;
    logic [PTR_W-1:0] find_ptr;

    // most negative value comes out as 2^(w-1), read unsigned
    assign magnitude = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

    // several double dabble bit steps per cycle
    always_comb
    begin
        conv_bits   = shift_reg;
        conv_digits = bcd_reg;
        conv_ovf    = overflow_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (conv_digits[d] >= BCD_ADJ_LIMIT)
                begin
                    conv_digits[d] = conv_digits[d] + BCD_ADJ;
                end
            end
            // carry out of the top digit: value no longer fits, keep the low digits
            conv_ovf = conv_ovf | conv_digits[MAX_DIGITS-1][3];
            for (int d = MAX_DIGITS - 1; d > 0; d--)
            begin
                conv_digits[d] = {conv_digits[d][2:0], conv_digits[d-1][3]};
            end
            conv_digits[0] = {conv_digits[0][2:0], conv_bits[PAD_W-1]};
            conv_bits      = {conv_bits[PAD_W-2:0], 1'b0};
        end
    end

    // highest non-zero digit, zero gives a single digit, overflow selects the top digit
    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            if (bcd_reg[d] != 4'd0)
            begin
                top_idx = PTR_W'(d);
            end
        end
        find_ptr = overflow_reg ? PTR_W'(MAX_DIGITS - 1) : top_idx;
    end

    always_comb
    begin
        shift_next    = shift_reg;
        bcd_next      = bcd_reg;
        overflow_next = overflow_reg;
        sign_next     = sign_reg;
        ptr_next      = ptr_reg;
        char_next     = char_reg;
        last_next     = last_reg;

        if (cmd.start)
        begin
            shift_next    = PAD_W'(magnitude);
            overflow_next = 1'b0;
            sign_next     = value[VALUE_WIDTH-1];
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                bcd_next[d] = 4'd0;
            end
        end

        if (cmd.conv_step)
        begin
            shift_next    = conv_bits;
            bcd_next      = conv_digits;
            overflow_next = conv_ovf;
        end

        if (cmd.find)
        begin
            ptr_next = find_ptr;
        end

        if (cmd.load_char)
        begin
            if (sign_reg)
            begin
                sign_next = 1'b0;
                char_next = ASCII_MINUS;
                last_next = 1'b0;
            end
            else
            begin
                ptr_next  = ptr_reg - PTR_W'(1);
                char_next = ASCII_ZERO + {4'd0, bcd_reg[ptr_reg]};
                last_next = (ptr_reg == '0);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_char)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        bcd_reg      <= bcd_next;
        overflow_reg <= overflow_next;
        sign_reg     <= sign_next;
        ptr_reg      <= ptr_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.last_char = !sign_reg && (ptr_reg == '0);

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

@@ rtl/core/sitoa_ctrl.sv @@
// controller: sequences accept, conversion steps, digit search and character output
// depends on sitoa_pkg
module sitoa_ctrl
    import sitoa_pkg::*;
#(
    parameter int STEPS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sitoa_status_t status,
    output sitoa_cmd_t    cmd
);

    localparam int CNT_W = $clog2(STEPS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_FIND = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = S_CONV;
                    cnt_next   = '0;
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    state_next = S_FIND;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.load_char = status.out_free;
                if (status.out_free && status.last_char)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/core/signed_int_to_decimal_ascii_core.sv @@
// top level: signed integer in, decimal ascii characters out, one per transfer
// the first character follows the bcd conversion steps and the digit search after the input transfer
// one integer at a time, n characters each (up to 11 at 32 bits); paced by the 4-bit-per-cycle
// bcd conversion and one character per cycle out while the receiver is ready
// reset: rst_n clears controller state and output valid; no clearing pass
module signed_int_to_decimal_ascii_core
    import sitoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 10
) (
    input logic           clk,
    input logic           rst_n,
    sitoa_value_if.sink   num,
    sitoa_char_if.source  text
);

    localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;

    sitoa_cmd_t    cmd;
    sitoa_status_t status;

    sitoa_ctrl #(
        .STEPS (STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (num.valid),
        .in_ready (num.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sitoa_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (num.value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .char_code (text.char_code),
        .last      (text.last)
    );

`ifndef SYNTHESIS
    // one integer at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        num.valid && num.ready |=> !num.ready)
        else $error("input taken again straight after a transfer");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid |-> (text.char_code == ASCII_MINUS)
            || (text.char_code >= ASCII_ZERO && text.char_code <= ASCII_NINE))
        else $error("character outside minus and digits");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.char_code == ASCII_MINUS |-> !text.last)
        else $error("minus sign marked as final character");
`endif

endmodule
